/* sv/stephs_pkg.sv */
// shared types, request codes and coil patterns for the half-step sequencer
package stephs_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_OPEN      = 3'd1;
    localparam logic [2:0] REQ_CLOSE     = 3'd2;
    localparam logic [2:0] REQ_COILS_OFF = 3'd3;
    localparam logic [2:0] REQ_LOAD_POS  = 3'd4;
    localparam logic [2:0] REQ_LIMIT     = 3'd5;

    localparam int unsigned VALUE_BITS = 16;
    localparam int unsigned OUT_POS_BITS = 16;
    localparam logic [VALUE_BITS-1:0] STEP_LIMIT_RESET = 16'd90;
    localparam logic [3:0] COILS_OFF = 4'h0;

    // one accepted input word
    typedef struct packed {
        logic [2:0]            req_type;
        logic [VALUE_BITS-1:0] value;
    } req_word_t;

    // one result word
    typedef struct packed {
        logic [3:0]              coils;
        logic [OUT_POS_BITS-1:0] position;
        logic                    forward_active;
        logic                    reverse_active;
    } res_word_t;

    // forward half-step pattern
    function automatic logic [3:0] fwd_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hc;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // reverse half-step pattern
    function automatic logic [3:0] rev_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h1;
            3'd2:    pat = 4'h3;
            3'd3:    pat = 4'h2;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h4;
            3'd6:    pat = 4'hc;
            default: pat = 4'h8;
        endcase
        return pat;
    endfunction

endpackage

/* sv/stephs_in_reg.sv */
// input register stage holding one request word
module stephs_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  stephs_pkg::req_word_t in_word,
    input  logic                 advance,
    output logic                 s1_valid,
    output stephs_pkg::req_word_t s1_word
);
    import stephs_pkg::*;

    logic      valid_reg;
    req_word_t word_reg;

    // stage is free when empty or draining this cycle
    assign in_ready = !valid_reg || advance;
    assign s1_valid = valid_reg;
    assign s1_word  = word_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

/* sv/stephs_seq.sv */
// sequencer state and single-pass next-state logic
module stephs_seq #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  stephs_pkg::req_word_t        req,
    input  logic [stephs_pkg::VALUE_BITS-1:0] step_limit,
    output stephs_pkg::res_word_t        res
);
    import stephs_pkg::*;

    localparam int unsigned CMP_BITS =
        (POSITION_BITS > VALUE_BITS) ? POSITION_BITS : VALUE_BITS;

    logic [2:0]               fwd_phase_reg, fwd_phase_next;
    logic [2:0]               rev_phase_reg, rev_phase_next;
    logic                     fwd_run_reg, fwd_run_next;
    logic                     rev_run_reg, rev_run_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_fwd;
    logic [3:0]               coils_reg, coils_next;
    logic [CMP_BITS-1:0]      pos_wide, max_wide, val_wide, pos_next_wide;

    assign pos_wide = CMP_BITS'(pos_reg);
    assign max_wide = CMP_BITS'(step_limit);
    assign val_wide = CMP_BITS'(req.value);

    // forward half of a tick: count up, saturating
    assign pos_fwd = (fwd_run_reg && !(&pos_reg)) ? pos_reg + 1'b1 : pos_reg;

    // next state for the request in the stage
    always_comb
    begin
        fwd_phase_next = fwd_phase_reg;
        rev_phase_next = rev_phase_reg;
        fwd_run_next   = fwd_run_reg;
        rev_run_next   = rev_run_reg;
        pos_next       = pos_reg;
        coils_next     = coils_reg;
        case (req.req_type)
            REQ_TICK:
            begin
                if (fwd_run_reg)
                begin
                    coils_next     = fwd_pattern(fwd_phase_reg);
                    fwd_phase_next = fwd_phase_reg + 3'd1;
                end
                pos_next = pos_fwd;
                if (rev_run_reg)
                begin
                    coils_next     = rev_pattern(rev_phase_reg);
                    rev_phase_next = rev_phase_reg + 3'd1;
                    if (pos_fwd != '0)
                    begin
                        pos_next = pos_fwd - 1'b1;
                    end
                end
            end
            REQ_OPEN:
            begin
                fwd_run_next = 1'b0;
                if (pos_reg != '0)
                begin
                    rev_run_next = 1'b1;
                end
                else
                begin
                    rev_run_next = 1'b0;
                    coils_next   = COILS_OFF;
                end
            end
            REQ_CLOSE:
            begin
                rev_run_next = 1'b0;
                if (pos_wide < max_wide)
                begin
                    fwd_run_next = 1'b1;
                end
                else
                begin
                    fwd_run_next = 1'b0;
                    coils_next   = COILS_OFF;
                end
            end
            REQ_COILS_OFF:
            begin
                coils_next = COILS_OFF;
            end
            REQ_LOAD_POS:
            begin
                pos_next = val_wide[POSITION_BITS-1:0];
            end
            REQ_LIMIT:
            begin
                if (fwd_run_reg && (val_wide >= max_wide))
                begin
                    fwd_run_next = 1'b0;
                    coils_next   = COILS_OFF;
                end
                if (rev_run_reg && (req.value == '0))
                begin
                    rev_run_next = 1'b0;
                    coils_next   = COILS_OFF;
                end
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
    end

    // result reflects the state after this request
    assign pos_next_wide      = CMP_BITS'(pos_next);
    assign res.coils          = coils_next;
    assign res.position       = pos_next_wide[OUT_POS_BITS-1:0];
    assign res.forward_active = fwd_run_next;
    assign res.reverse_active = rev_run_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_phase_reg <= 3'd0;
            rev_phase_reg <= 3'd0;
            fwd_run_reg   <= 1'b0;
            rev_run_reg   <= 1'b0;
            pos_reg       <= '0;
            coils_reg     <= COILS_OFF;
        end
        else if (fire)
        begin
            fwd_phase_reg <= fwd_phase_next;
            rev_phase_reg <= rev_phase_next;
            fwd_run_reg   <= fwd_run_next;
            rev_run_reg   <= rev_run_next;
            pos_reg       <= pos_next;
            coils_reg     <= coils_next;
        end
    end

endmodule

/* sv/stepper_half_step_position_control_top.sv */
// top level: input stage, sequencer, result register and limit register
// Half-step stepper sequencer with position tracking. Each request word (tick,
// open, close, coils off, load position, limit check) gives exactly one result
// word carrying the coil drive bits, the low 16 bits of the step position and
// the two run flags as they stand after that request. A word passes an input
// register, one pass of next-state logic and a result register, and a new word
// can be taken every cycle while the result side keeps up; the position and
// phase registers are updated in one pass per word, which sets that rate. The
// step limit resets to 90; the user must write it through the cfg channel only
// while the block is idle, and the block itself does not enforce this.
module stepper_half_step_position_control_top #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  coils,
    output logic [15:0] position,
    output logic        forward_active,
    output logic        reverse_active
);
    import stephs_pkg::*;

    logic                  s1_valid;
    logic                  fire;
    logic                  out_room;
    req_word_t             in_word, s1_word;
    res_word_t             res_next, res_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] step_limit_reg;

    assign in_word.req_type = req_type;
    assign in_word.value    = value;

    // result register has room when empty or being taken
    assign out_room = !out_valid_reg || out_ready;
    assign fire     = s1_valid && out_room;

    stephs_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .advance  (out_room),
        .s1_valid (s1_valid),
        .s1_word  (s1_word)
    );

    stephs_seq #(
        .POSITION_BITS (POSITION_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req        (s1_word),
        .step_limit (step_limit_reg),
        .res        (res_next)
    );

    // limit register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg <= STEP_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            step_limit_reg <= cfg_data;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_room)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign coils          = res_reg.coils;
    assign position       = res_reg.position;
    assign forward_active = res_reg.forward_active;
    assign reverse_active = res_reg.reverse_active;

endmodule

/* test/tb_stepper_half_step_position_control_top.sv */
// testbench for the half-step stepper sequencer with position tracking
module tb_stepper_half_step_position_control_top;
    import stephs_pkg::*;

    // request codes the block treats as no-ops
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam logic [15:0] STEP_LIMIT_MIN = 16'd1;
    localparam logic [15:0] STEP_LIMIT_TOP = 16'hffff;
    localparam logic [15:0] POS_TOP        = 16'hffff;

    // half-step coil sequences, phase 0 in the low nibble
    localparam logic [31:0] FWD_SEQ = 32'h913264c8;
    localparam logic [31:0] REV_SEQ = 32'h8c462319;

    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  req_type = REQ_TICK;
    logic [15:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  coils;
    logic [15:0] position;
    logic        forward_active;
    logic        reverse_active;

    // sequencer state as the block should hold it
    logic [2:0]  fwd_phase = '0;
    logic [2:0]  rev_phase = '0;
    logic        fwd_run = 1'b0;
    logic        rev_run = 1'b0;
    logic [15:0] step_pos = '0;
    logic [3:0]  coil_drv = COILS_OFF;
    logic [15:0] step_limit_cfg = STEP_LIMIT_RESET;

    res_word_t expected_words[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned words_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatch_count = 0;
    int unsigned drain_wait;

    stepper_half_step_position_control_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .coils          (coils),
        .position       (position),
        .forward_active (forward_active),
        .reverse_active (reverse_active)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t  %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // advance the sequencer state by one request and queue the word it yields
    task automatic step_sequencer(input logic [2:0] req, input logic [15:0] val);
        res_word_t word;
        case (req)
            REQ_TICK:
            begin
                if (fwd_run)
                begin
                    coil_drv = FWD_SEQ[{fwd_phase, 2'b00} +: 4];
                    fwd_phase = fwd_phase + 3'd1;
                    if (step_pos != POS_TOP)
                        step_pos = step_pos + 16'd1;
                end
                if (rev_run)
                begin
                    coil_drv = REV_SEQ[{rev_phase, 2'b00} +: 4];
                    rev_phase = rev_phase + 3'd1;
                    if (step_pos != 16'd0)
                        step_pos = step_pos - 16'd1;
                end
            end
            REQ_OPEN:
            begin
                if (step_pos != 16'd0)
                begin
                    rev_run = 1'b1;
                    fwd_run = 1'b0;
                end
                else
                begin
                    rev_run = 1'b0;
                    fwd_run = 1'b0;
                    coil_drv = COILS_OFF;
                end
            end
            REQ_CLOSE:
            begin
                if (step_pos < step_limit_cfg)
                begin
                    fwd_run = 1'b1;
                    rev_run = 1'b0;
                end
                else
                begin
                    fwd_run = 1'b0;
                    rev_run = 1'b0;
                    coil_drv = COILS_OFF;
                end
            end
            REQ_COILS_OFF:
                coil_drv = COILS_OFF;
            REQ_LOAD_POS:
                step_pos = val;
            REQ_LIMIT:
            begin
                if (fwd_run && val >= step_limit_cfg)
                begin
                    fwd_run = 1'b0;
                    coil_drv = COILS_OFF;
                end
                if (rev_run && val == 16'd0)
                begin
                    rev_run = 1'b0;
                    coil_drv = COILS_OFF;
                end
            end
            default:
                ;
        endcase
        word.coils = coil_drv;
        word.position = step_pos;
        word.forward_active = fwd_run;
        word.reverse_active = rev_run;
        expected_words.push_back(word);
    endtask

    // send one request word, with random idle cycles ahead of it
    task automatic send_req(input logic [2:0] req, input logic [15:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_sequencer(req, val);
        items_sent++;
    endtask

    // stop sending and let every outstanding word come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_step_limit(input logic [15:0] steps);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= steps;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        step_limit_cfg = steps;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // position to load: anywhere, near the limit, near the top, or near zero
    function automatic logic [15:0] pick_load_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return step_limit_cfg - 16'($urandom_range(0, 3));
            2:       return POS_TOP - 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, 5));
        endcase
    endfunction

    // value for a limit check: the current position half the time, as a controller would
    function automatic logic [15:0] pick_limit_value();
        case ($urandom_range(0, 5))
            0, 1, 2: return step_pos;
            3:       return step_limit_cfg;
            4:       return 16'd0;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // idle state, closing through a full phase cycle, coils off, stops, opening to zero
    task automatic test_reset_and_motion();
        set_idling(0, 0);
        send_req(REQ_TICK, 16'h0000);
        send_req(REQ_OPEN, 16'h0000);
        send_req(REQ_CLOSE, 16'hffff);
        repeat (9) send_req(REQ_TICK, 16'haaaa);
        send_req(REQ_COILS_OFF, 16'h5555);
        send_req(REQ_TICK, 16'h0000);
        send_req(REQ_LIMIT, 16'd5);
        send_req(REQ_LIMIT, 16'hffff);
        send_req(REQ_LOAD_POS, 16'd3);
        send_req(REQ_OPEN, 16'h5555);
        repeat (5) send_req(REQ_TICK, 16'hffff);
        send_req(REQ_LIMIT, 16'h0000);
        send_req(REQ_SPARE_6, 16'hffff);
        send_req(REQ_SPARE_7, 16'h0000);
    endtask

    // saturation at the top of the range, and the smallest step limit
    task automatic test_limits_and_saturation();
        set_step_limit(STEP_LIMIT_TOP);
        send_req(REQ_LOAD_POS, POS_TOP - 16'd3);
        send_req(REQ_CLOSE, 16'h0000);
        repeat (4) send_req(REQ_TICK, 16'h0000);
        send_req(REQ_LIMIT, 16'hffff);
        set_step_limit(STEP_LIMIT_MIN);
        send_req(REQ_LOAD_POS, 16'd0);
        send_req(REQ_CLOSE, 16'h0000);
        send_req(REQ_TICK, 16'h0000);
        send_req(REQ_CLOSE, 16'h0000);
        send_req(REQ_OPEN, 16'h0000);
        repeat (2) send_req(REQ_TICK, 16'h0000);
        send_req(REQ_LIMIT, 16'h0000);
    endtask

    // motion bursts with position feedback, mixed with loose requests
    task automatic run_traffic(input int unsigned n_items);
        int unsigned start;
        int unsigned n_ticks;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 99) < 72)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_req(REQ_LOAD_POS, pick_load_value());
                send_req($urandom_range(0, 1) ? REQ_CLOSE : REQ_OPEN,
                         16'($urandom_range(0, 65535)));
                n_ticks = $urandom_range(1, 24);
                repeat (n_ticks)
                begin
                    send_req(REQ_TICK, 16'($urandom_range(0, 65535)));
                    if ($urandom_range(0, 99) < 40)
                        send_req(REQ_LIMIT, pick_limit_value());
                end
                if ($urandom_range(0, 99) < 15)
                    send_req(REQ_COILS_OFF, 16'($urandom_range(0, 65535)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       send_req(3'($urandom_range(0, 7)),
                                      16'($urandom_range(0, 65535)));
                    1:       send_req(REQ_LOAD_POS, pick_load_value());
                    default: send_req(REQ_LIMIT, pick_limit_value());
                endcase
            end
        end
    endtask

    // random traffic over several step limit settings and idling modes
    task automatic test_random_traffic();
        int unsigned ph;
        logic [15:0] steps;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       steps = STEP_LIMIT_RESET;
                1:       steps = STEP_LIMIT_MIN;
                2:       steps = STEP_LIMIT_TOP;
                3:       steps = 16'($urandom_range(2, 200));
                4:       steps = 16'($urandom_range(1, 65535));
                5:       steps = 16'($urandom_range(2, 40));
                6:       steps = STEP_LIMIT_TOP;
                default: steps = STEP_LIMIT_MIN;
            endcase
            set_step_limit(steps);
            case (ph % 4)
                0:       set_idling(0, 0);
                1:       set_idling(69, 0);
                2:       set_idling(0, 69);
                default: set_idling(16, 16);
            endcase
            run_traffic(250);
        end
    endtask

    // result side stalls at random
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // compare each result word with the oldest expected one
    always @(posedge clk)
    begin : check_results
        res_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result word with none expected",
                                32'({coils, position}), 32'd0);
            else
            begin
                want = expected_words.pop_front();
                if (coils !== want.coils)
                    report_mismatch("coils", 32'(coils), 32'(want.coils));
                if (position !== want.position)
                    report_mismatch("position", 32'(position), 32'(want.position));
                if (forward_active !== want.forward_active)
                    report_mismatch("forward_active", 32'(forward_active),
                                    32'(want.forward_active));
                if (reverse_active !== want.reverse_active)
                    report_mismatch("reverse_active", 32'(reverse_active),
                                    32'(want.reverse_active));
                words_checked++;
            end
        end
    end

    // main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_and_motion();
        test_limits_and_saturation();
        test_random_traffic();
        @(negedge clk);
        in_valid <= 1'b0;
        drain_wait = 0;
        while (expected_words.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("result words never returned", 32'd0,
                            32'(expected_words.size()));
        $display("sent %0d requests, checked %0d result words, %0d step limit writes",
                 items_sent, words_checked, cfg_writes);
        $display("idling modes: none, sender 69%%, receiver 69%%, both 16%%");
        if (mismatch_count == 0)
            $display("stepper_half_step_position_control_top: match");
        else
            $display("stepper_half_step_position_control_top: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("timeout waiting on the block");
        $display("stepper_half_step_position_control_top: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
sv/stephs_pkg.sv
sv/stephs_in_reg.sv
sv/stephs_seq.sv
sv/stepper_half_step_position_control_top.sv
test/tb_stepper_half_step_position_control_top.sv
